// ===== rtl/rounded_corner_pixel_mask_core_macros.svh =====
// Assertion macros shared by the rounded corner mask RTL.
// Included by the modules that carry concurrent checks.
`ifndef ROUNDED_CORNER_PIXEL_MASK_CORE_MACROS_SVH
`define ROUNDED_CORNER_PIXEL_MASK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCPM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rcpm_pkg.sv =====
// Shared types, register indexes and default sizes for the rounded corner mask.
// No dependencies.
`timescale 1ns / 1ps
package rcpm_pkg;

  localparam int RCPM_MAX_WIDTH  = 2048;
  localparam int RCPM_MAX_HEIGHT = 2048;
  localparam int RCPM_COV_FRAC   = 12;

  // Half-pixel distance offsets fit in 11 bits, so the root has 12 integer bits.
  localparam int DIST_W     = 11;
  localparam int ROOT_INT_W = 12;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_BOTTOM  = 3'd4;

  typedef struct packed {
    logic              corner;
    logic [10:0]       r;
    logic [DIST_W-1:0] dx2;
    logic [DIST_W-1:0] dy2;
    logic [31:0]       px;
  } geom_t;

  typedef struct packed {
    logic        corner;
    logic [10:0] r;
    logic [31:0] px;
  } tag_t;

endpackage

// ===== rtl/rounded_corner_pixel_mask_core.sv =====
// Rounded corner band mask for a premultiplied ARGB pixel stream. Each beat
// carries one pixel with its column and row; rows outside the band and
// columns beyond the frame come out zero, corner pixels are scaled by an
// antialiased coverage. One beat is taken every cycle while the output is not
// stalled; the square root, which resolves one root bit per stage, makes up
// most of the pipeline. A stalled output holds the whole pipeline. Register
// writes take effect for beats accepted in a later cycle than the write.
`timescale 1ns / 1ps
`include "rounded_corner_pixel_mask_core_macros.svh"
module rounded_corner_pixel_mask_core import rcpm_pkg::*; #(
  parameter int MAX_WIDTH          = RCPM_MAX_WIDTH,
  parameter int MAX_HEIGHT         = RCPM_MAX_HEIGHT,
  parameter int COVERAGE_FRAC_BITS = RCPM_COV_FRAC
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_wr_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [55:0]          s_tdata,  // pixel_in[31:0], column[42:32], row[53:43], zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata   // pixel_out[31:0]
);

  localparam int ROOT_W = ROOT_INT_W + COVERAGE_FRAC_BITS;
  localparam int SQ_W   = 2 * DIST_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int TAG_W  = $bits(tag_t);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic  g_vld;
  geom_t g;

  rcpm_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .en           (en),
    .in_valid     (s_tvalid),
    .in_px        (s_tdata[31:0]),
    .in_col       (s_tdata[42:32]),
    .in_row       (s_tdata[53:43]),
    .out_valid    (g_vld),
    .out_geom     (g)
  );

  logic            sq_vld, sum_vld;
  logic [SQ_W-1:0] dx_sq, dy_sq;
  logic [SUM_W-1:0] dist_sq;
  tag_t            sq_tag, sum_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld  <= 1'b0;
      sum_vld <= 1'b0;
    end else if (en) begin
      sq_vld  <= g_vld;
      sum_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_sq   <= g.dx2 * g.dx2;
      dy_sq   <= g.dy2 * g.dy2;
      sq_tag  <= '{corner: g.corner, r: g.r, px: g.px};
      dist_sq <= {1'b0, dx_sq} + {1'b0, dy_sq};
      sum_tag <= sq_tag;
    end
  end

  logic              rt_vld;
  logic [ROOT_W-1:0] root;
  logic [TAG_W-1:0]  rt_tag_bits;
  tag_t              rt_tag;

  rcpm_isqrt #(
    .ROOT_W (ROOT_W),
    .TAG_W  (TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sum_vld),
    .in_v      ((2*ROOT_W)'(dist_sq) << (2 * COVERAGE_FRAC_BITS)),
    .in_tag    (sum_tag),
    .out_valid (rt_vld),
    .out_root  (root),
    .out_tag   (rt_tag_bits)
  );

  assign rt_tag = tag_t'(rt_tag_bits);

  rcpm_scale #(
    .COVERAGE_FRAC_BITS (COVERAGE_FRAC_BITS),
    .ROOT_W             (ROOT_W)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_vld),
    .in_root   (root),
    .in_tag    (rt_tag),
    .out_valid (m_tvalid),
    .out_px    (m_tdata)
  );

  // Corner offsets are odd half-pixel distances and need a nonzero radius.
  `RCPM_ASSERT_IMP(a_corner_odd, clk, rst, g_vld && g.corner, g.dx2[0] && g.dy2[0] && (g.r != 11'd0), "corner offsets malformed")
  // A held output beat must hold the input side too.
  `RCPM_ASSERT_IMP(a_stall_ready, clk, rst, m_tvalid && !m_tready, !s_tready, "input taken during output stall")
  // A corner pixel is never at the circle center, so its root is nonzero.
  `RCPM_ASSERT_IMP(a_root_nonzero, clk, rst, rt_vld && rt_tag.corner, root != '0, "zero root for a corner pixel")

endmodule

// ===== rtl/rcpm_geom.sv =====
// Configuration registers, band geometry and corner distance offsets.
// Depends on rcpm_pkg.
`timescale 1ns / 1ps
module rcpm_geom import rcpm_pkg::*; #(
  parameter int MAX_WIDTH  = RCPM_MAX_WIDTH,
  parameter int MAX_HEIGHT = RCPM_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_wr_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          in_px,
  input  logic [10:0]          in_col,
  input  logic [10:0]          in_row,
  output logic                 out_valid,
  output geom_t                out_geom
);

  logic [11:0] frame_width, frame_height, band_top, band_bottom;
  logic [10:0] corner_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 12'd2048;
      frame_height  <= 12'd2048;
      corner_radius <= 11'd0;
      band_top      <= 12'd0;
      band_bottom   <= 12'd2048;
    end else if (cfg_wr_en) begin
      case (cfg_wr_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_wr_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_wr_data;
        REG_CORNER_RADIUS: corner_radius <= cfg_wr_data[10:0];
        REG_BAND_TOP:      band_top      <= cfg_wr_data;
        REG_BAND_BOTTOM:   band_bottom   <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Band limits are registered and settle in the cycle after a write.
  logic [11:0] w_c, h_c, bot_c, top_c, span_c;
  logic [10:0] r_c;
  logic [11:0] w, top, bottom, top_r, bot_r, w_r;
  logic [10:0] r;

  always_comb begin
    w_c   = (32'(frame_width) > MAX_WIDTH) ? 12'(MAX_WIDTH) : frame_width;
    h_c   = (32'(frame_height) > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : frame_height;
    bot_c = (band_bottom > h_c) ? h_c : band_bottom;
    top_c = (band_top > bot_c) ? bot_c : band_top;
    span_c = bot_c - top_c;
    r_c = corner_radius;
    if (r_c > w_c[11:1]) r_c = w_c[11:1];
    if (r_c > span_c[11:1]) r_c = span_c[11:1];
  end

  always_ff @(posedge clk) begin
    w      <= w_c;
    top    <= top_c;
    bottom <= bot_c;
    r      <= r_c;
    top_r  <= top_c + {1'b0, r_c};
    bot_r  <= bot_c - {1'b0, r_c};
    w_r    <= w_c - {1'b0, r_c};
  end

  logic [31:0] px_q;
  logic [10:0] col_q, row_q;
  logic        vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_q  <= in_px;
      col_q <= in_col;
      row_q <= in_row;
    end
  end

  logic [11:0] col12, row12, dy_top, dy_bot, dx_lft, dx_rgt;
  logic        inband, ytop, ybot, xlft, xrgt;
  geom_t       g_next;

  always_comb begin
    col12  = {1'b0, col_q};
    row12  = {1'b0, row_q};
    inband = (row12 >= top) && (row12 < bottom) && (col12 < w);
    ytop   = row12 < top_r;
    ybot   = row12 >= bot_r;
    xlft   = col12 < {1'b0, r};
    xrgt   = col12 >= w_r;
    dy_top = {top_r[10:0] - row12[10:0], 1'b0} - 12'd1;
    dy_bot = {row12[10:0] - bot_r[10:0], 1'b1};
    dx_lft = {r - col12[10:0], 1'b0} - 12'd1;
    dx_rgt = {col12[10:0] - w_r[10:0], 1'b1};
    g_next.corner = inband && (r != 11'd0) && (ytop || ybot) && (xlft || xrgt);
    g_next.r      = r;
    g_next.dy2    = ytop ? dy_top[DIST_W-1:0] : dy_bot[DIST_W-1:0];
    g_next.dx2    = xlft ? dx_lft[DIST_W-1:0] : dx_rgt[DIST_W-1:0];
    g_next.px     = inband ? px_q : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_geom <= g_next;
    end
  end

endmodule

// ===== rtl/rcpm_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on rcpm_pkg; carries a sideband tag alongside each operand.
`timescale 1ns / 1ps
`include "rounded_corner_pixel_mask_core_macros.svh"
module rcpm_isqrt import rcpm_pkg::*; #(
  parameter int ROOT_W = ROOT_INT_W + RCPM_COV_FRAC,
  parameter int TAG_W  = $bits(tag_t)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_v,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int RW2 = 2 * ROOT_W;
  localparam logic [RW2-1:0] ONE = RW2'(1);

  logic [RW2-1:0]    rem [0:ROOT_W];
  logic [ROOT_W-1:0] q   [0:ROOT_W];
  logic [TAG_W-1:0]  tag [0:ROOT_W];
  logic              vld [0:ROOT_W];

  assign rem[0] = in_v;
  assign q[0]   = '0;
  assign tag[0] = in_tag;
  assign vld[0] = in_valid;

  // Stage k decides root bit ROOT_W-1-k; rem holds the operand minus q squared.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [RW2-1:0] trial;
    logic           take;

    assign trial = ({{ROOT_W{1'b0}}, q[k]} << (B + 1)) | (ONE << (2 * B));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= take ? rem[k] - trial : rem[k];
        q[k+1]   <= take ? (q[k] | (ROOT_W'(1) << B)) : q[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = q[ROOT_W];
  assign out_tag   = tag[ROOT_W];

  // A floor root leaves a remainder no larger than twice the root.
  `RCPM_ASSERT_IMP(a_rem_bound, clk, rst, vld[ROOT_W], rem[ROOT_W] <= {{(ROOT_W-1){1'b0}}, q[ROOT_W], 1'b0}, "square root remainder out of range")

endmodule

// ===== rtl/rcpm_scale.sv =====
// Coverage from the root, then per-byte scaling with round half up.
// Depends on rcpm_pkg; the last register is the output beat register.
`timescale 1ns / 1ps
module rcpm_scale import rcpm_pkg::*; #(
  parameter int COVERAGE_FRAC_BITS = RCPM_COV_FRAC,
  parameter int ROOT_W = ROOT_INT_W + COVERAGE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [31:0]       out_px
);

  localparam int F = COVERAGE_FRAC_BITS;

  logic [ROOT_W-1:0] num, diff;
  logic [ROOT_W-1:0] cov_full;
  logic              pass_c;

  always_comb begin
    num      = ROOT_W'({in_tag.r, 1'b1}) << F;
    diff     = num - in_root;
    cov_full = (in_root >= num) ? '0 : {1'b0, diff[ROOT_W-1:1]};
    pass_c   = !in_tag.corner || (cov_full >= (ROOT_W'(1) << F));
  end

  logic [F-1:0] cov;
  logic         pass, vld_c;
  logic [31:0]  px_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (en) begin
      vld_c <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov  <= cov_full[F-1:0];
      pass <= pass_c;
      px_c <= in_tag.px;
    end
  end

  logic [31:0] scaled;

  for (genvar b = 0; b < 4; b++) begin : g_byte
    logic [F+7:0] rnd;
    assign rnd = px_c[8*b +: 8] * cov + ((F+8)'(1) << (F - 1));
    assign scaled[8*b +: 8] = rnd[F +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px <= pass ? px_c : scaled;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for rounded_corner_pixel_mask_core: random and directed pixels
// against a built-in predictor of the rounded band mask. Depends on rcpm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import rcpm_pkg::*;

  localparam int FRAC = RCPM_COV_FRAC;
  localparam int LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] column;
    logic [31:0] pixel;
  } beat_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_wr_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;

  rounded_corner_pixel_mask_core dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the mask registers.
  int unsigned frm_w = 2048, frm_h = 2048, rad = 0, b_top = 0, b_bot = 2048;

  beat_t pending_pixels[$];
  logic [31:0] expected_pixels[$];
  int mismatches = 0, results_seen = 0, cycles = 0;
  int corner_hits = 0;
  bit quiet = 0;  // no idling once set
  bit hold_send = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] masked_pixel(beat_t b);
    int unsigned w, h, bot, top, r, dy2, xx, col, row;
    longint unsigned dx2, s, root, num, cov, c, v;
    logic [31:0] res;
    col = b.column;
    row = b.row;
    w = frm_w > 2048 ? 2048 : frm_w;
    h = frm_h > 2048 ? 2048 : frm_h;
    bot = b_bot > h ? h : b_bot;
    top = b_top > bot ? bot : b_top;
    r = rad;
    if (r > w / 2) r = w / 2;
    if (r > (bot - top) / 2) r = (bot - top) / 2;
    if (row < top || row >= bot || col >= w) return '0;
    if (r == 0) return b.pixel;
    if (row < top + r) dy2 = 2 * (top + r - row) - 1;
    else if (row >= bot - r) dy2 = 2 * (row - (bot - r)) + 1;
    else return b.pixel;
    if (col < r) xx = col;
    else if (col >= w - r) xx = w - 1 - col;
    else return b.pixel;
    dx2 = 2 * longint'(r - xx) - 1;
    s = dx2 * dx2 + longint'(dy2) * dy2;
    root = int_sqrt(s << (2 * FRAC));
    num = (2 * longint'(r) + 1) << FRAC;
    cov = root >= num ? 0 : (num - root) >> 1;
    if (cov >= (64'd1 << FRAC)) return b.pixel;
    corner_hits++;
    res = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      c = (b.pixel >> sh) & 8'hff;
      v = (c * cov + (64'd1 << (FRAC - 1))) >> FRAC;
      if (v > 255) v = 255;
      res |= v[7:0] << sh;
    end
    return res;
  endfunction

  // Driver: one beat held until accepted, random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_pixels.push_back(masked_pixel(beat_t'(s_tdata[53:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 0;
        end else if (!hold_send && pending_pixels.size() > 0) begin
          s_tvalid <= 1;
          s_tdata <= {2'b0, pending_pixels.pop_front()};
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 6);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // Monitor with random back-pressure.
  int stall = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h", m_tdata);
        end else begin
          logic [31:0] want;
          want = expected_pixels.pop_front();
          if (want !== m_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %h got %h", want, m_tdata);
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        m_tready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall <= $urandom_range(1, 6);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_index <= idx;
    cfg_wr_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 0;
    case (idx)
      REG_FRAME_WIDTH: frm_w = val & 12'hfff;
      REG_FRAME_HEIGHT: frm_h = val & 12'hfff;
      REG_CORNER_RADIUS: rad = val & 11'h7ff;
      REG_BAND_TOP: b_top = val & 12'hfff;
      REG_BAND_BOTTOM: b_bot = val & 12'hfff;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_mask(input int unsigned w, h, r, t, b);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, r);
    write_reg(REG_BAND_TOP, t);
    write_reg(REG_BAND_BOTTOM, b);
  endtask

  // Waits until every queued pixel has been sent and has come back, then idles before returning.
  task automatic drain();
    while (pending_pixels.size() > 0 || s_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (FRAC + 30) @(posedge clk);
  endtask

  function automatic beat_t rand_beat(int unsigned w, h);
    beat_t b;
    b.pixel = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      b.column = 11'($urandom_range(0, 2047));
      b.row = 11'($urandom_range(0, 2047));
    end else begin
      b.column = 11'($urandom_range(0, w > 2048 ? 2047 : (w == 0 ? 0 : w - 1)));
      b.row = 11'($urandom_range(0, h > 2048 ? 2047 : (h == 0 ? 0 : h - 1)));
    end
    return b;
  endfunction

  initial begin
    int unsigned w, h, r, t, bt;
    beat_t b;
    repeat (4) @(posedge clk);
    rst <= 0;

    // Directed: small frame with rounded corners, corners, edges and band limits.
    set_mask(16, 12, 4, 2, 10);
    pending_pixels.push_back('{row: 2, column: 0, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 2, column: 15, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 9, column: 0, pixel: 32'h80ff4020});
    pending_pixels.push_back('{row: 9, column: 15, pixel: 32'h01020304});
    pending_pixels.push_back('{row: 3, column: 1, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 5, column: 3, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 6, column: 8, pixel: 32'h12345678});
    pending_pixels.push_back('{row: 1, column: 8, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 10, column: 8, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 6, column: 16, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 11'h7ff, column: 11'h7ff, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 2, column: 2, pixel: 32'h00000000});
    // No new pixels are queued here until everything so far has come back.
    drain();
    // Oversized frame, radius above limit, bottom beyond height.
    set_mask(4095, 4095, 2047, 0, 4095);
    pending_pixels.push_back('{row: 0, column: 0, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 2047, column: 2047, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 1024, column: 1024, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 0, column: 1024, pixel: 32'hffffffff});
    drain();
    // Zero width with top above bottom, then a one-pixel frame with the band beyond its height.
    set_mask(0, 0, 0, 4095, 0);
    pending_pixels.push_back('{row: 0, column: 0, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 5, column: 5, pixel: 32'hffffffff});
    drain();
    set_mask(1, 1, 1, 2048, 2048);
    pending_pixels.push_back('{row: 0, column: 0, pixel: 32'hffffffff});
    drain();
    write_reg(REG_UNUSED, 12'h123);  // unused index, must change nothing
    set_mask(20, 20, 6, 3, 19);
    pending_pixels.push_back('{row: 3, column: 0, pixel: 32'hffffffff});
    pending_pixels.push_back('{row: 18, column: 19, pixel: 32'hffffffff});
    drain();

    // Random phases: mostly small frames so corners are hit often.
    for (int ph = 0; ph < 25; ph++) begin
      if (ph == 20) quiet = 1;
      if (ph % 6 == 5) begin
        w = $urandom_range(1, 4095);
        h = $urandom_range(1, 4095);
      end else begin
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 64);
      end
      r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 32);
      t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, h / 3);
      bt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(h / 2, h + 4);
      set_mask(w, h, r, t, bt);
      for (int i = 0; i < 50; i++) begin
        b = rand_beat(w, h);
        pending_pixels.push_back(b);
      end
      drain();
    end

    $display("covered %0d pixels, %0d with partial corner coverage, 30 mask settings",
             results_seen, corner_hits);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
